// File: hdl/mpe_pkg.sv
package mpe_pkg;

   localparam int MUL_OP_W = 4;

   localparam logic [MUL_OP_W-1:0] MUL_NONE     = 4'd0;
   localparam logic [MUL_OP_W-1:0] MUL_RX_RX    = 4'd1;
   localparam logic [MUL_OP_W-1:0] MUL_RY_RY    = 4'd2;
   localparam logic [MUL_OP_W-1:0] MUL_RX2_RY   = 4'd3;
   localparam logic [MUL_OP_W-1:0] MUL_X_X1     = 4'd4;
   localparam logic [MUL_OP_W-1:0] MUL_RY2_P    = 4'd5;
   localparam logic [MUL_OP_W-1:0] MUL_YM1_SQ   = 4'd6;
   localparam logic [MUL_OP_W-1:0] MUL_RX2_P    = 4'd7;
   localparam logic [MUL_OP_W-1:0] MUL_RX2_RY2  = 4'd8;

   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_X = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS_X = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS_Y = 2'd3;

   localparam logic [1:0] PH_DONE = 2'd0;
   localparam logic [1:0] PH_R1   = 2'd1;
   localparam logic [1:0] PH_R2   = 2'd2;

endpackage

// File: hdl/mpe_mul.sv
module mpe_mul import mpe_pkg::*; #(
   parameter int COORD_WIDTH = 12
) (
   input  logic                       clock,
   input  logic [MUL_OP_W-1:0]        op,
   input  logic [COORD_WIDTH-2:0]     radius_x,
   input  logic [COORD_WIDTH-2:0]     radius_y,
   input  logic [2*COORD_WIDTH-3:0]   rx2,
   input  logic [2*COORD_WIDTH-3:0]   ry2,
   input  logic [COORD_WIDTH-1:0]     off_x,
   input  logic [COORD_WIDTH:0]       y_mag,
   output logic [4*COORD_WIDTH-1:0]   prod_ff
);

   localparam int AW = 2*COORD_WIDTH - 2;
   localparam int BW = 2*COORD_WIDTH + 2;
   localparam int PW = AW + BW;

   logic [AW-1:0] opa;
   logic [BW-1:0] opb;
   logic [PW-1:0] prod_in;

   // x*(x+1) and ym1^2 both fit in BW bits, so the product feeds back directly
   always_comb begin
      opa = '0;
      opb = '0;
      unique case (op)
         MUL_NONE: begin
            opa = '0;
            opb = '0;
         end
         MUL_RX_RX: begin
            opa = AW'(radius_x);
            opb = BW'(radius_x);
         end
         MUL_RY_RY: begin
            opa = AW'(radius_y);
            opb = BW'(radius_y);
         end
         MUL_RX2_RY: begin
            opa = rx2;
            opb = BW'(radius_y);
         end
         MUL_X_X1: begin
            opa = AW'(off_x);
            opb = BW'(off_x) + BW'(1);
         end
         MUL_RY2_P: begin
            opa = ry2;
            opb = prod_ff[BW-1:0];
         end
         MUL_YM1_SQ: begin
            opa = AW'(y_mag);
            opb = BW'(y_mag);
         end
         MUL_RX2_P: begin
            opa = rx2;
            opb = prod_ff[BW-1:0];
         end
         MUL_RX2_RY2: begin
            opa = rx2;
            opb = BW'(ry2);
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   assign prod_in = PW'(opa) * PW'(opb);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// File: hdl/midpoint_ellipse_point_generator_core.sv
// Midpoint ellipse rasterizer. Center and semi-axes come from four csr
// registers (center_x, center_y, radius_x, radius_y) and are read live by
// every transaction. A req transaction with restart set starts a new walk at
// offset (0, radius_y); every req transaction returns one rsp transaction
// with the four symmetric points, valid_res in tuser and tlast on the final
// set. After the walk ends, rsp carries all zeros. All products go through a
// single registered multiplier shared under a sequencer, so req_tready is low
// while an item is at work: a step runs the step states and pushes once the
// rsp register is free, a restart first loads the region 1 start values, and
// req_tready returns as the rsp register loads; an item on which the walk
// crosses into region 2 also computes the region 2 start value (rx^2*ry^2 and
// friends). The rsp output register holds a result until taken; the next req
// is accepted meanwhile but its result waits for that register.
module midpoint_ellipse_point_generator_core import mpe_pkg::*; #(
   parameter int COORD_WIDTH = 12
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]                    csr_index,
   input  logic [COORD_WIDTH-1:0]                    csr_data,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [7:0]                                req_tdata,   // [0] restart
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
   output logic [((8*(COORD_WIDTH+2)+7)/8)*8-1:0]    rsp_tdata,
   output logic [0:0]                                rsp_tuser,   // [0] valid_res
   output logic                                      rsp_tlast
);

   localparam int CW    = COORD_WIDTH;
   localparam int RW    = CW - 1;
   localparam int R2W   = 2*CW - 2;
   localparam int YW    = CW + 1;
   localparam int OW    = CW + 2;
   localparam int SW    = 3*CW + 4;
   localparam int DW    = ((4*CW + 2) > 64) ? 64 : (4*CW + 2);
   localparam int PW    = 4*CW;
   localparam int EXT   = DW - SW;
   localparam int RSP_W = ((8*OW + 7)/8)*8;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_SQ_RY   = 4'd1;
   localparam logic [3:0] S_SQ_DONE = 4'd2;
   localparam logic [3:0] S_INIT    = 4'd3;
   localparam logic [3:0] S_SETTLE  = 4'd4;
   localparam logic [3:0] S_T1      = 4'd5;
   localparam logic [3:0] S_T2      = 4'd6;
   localparam logic [3:0] S_T3      = 4'd7;
   localparam logic [3:0] S_T4      = 4'd8;
   localparam logic [3:0] S_T5      = 4'd9;
   localparam logic [3:0] S_EMIT    = 4'd10;
   localparam logic [3:0] S_STEP1   = 4'd11;
   localparam logic [3:0] S_STEP2   = 4'd12;
   localparam logic [3:0] S_PUSH    = 4'd13;

   logic [3:0]        state_ff, state_in;
   logic [1:0]        phase_ff, phase_in;
   logic              restart_ff, restart_in;
   logic              post_ff, post_in;
   logic              tx_ff, tx_in;
   logic              ty_ff, ty_in;
   logic [CW-1:0]     x_ff, x_in;
   logic [YW-1:0]     y_ff, y_in;
   logic [SW-1:0]     sx_ff, sx_in;
   logic [SW-1:0]     sy_ff, sy_in;
   logic [DW-1:0]     dec_ff, dec_in;
   logic [DW-1:0]     acc_ff, acc_in;
   logic [R2W-1:0]    rx2_ff, rx2_in;
   logic [R2W-1:0]    ry2_ff, ry2_in;
   logic [CW-1:0]     pt_x_ff, pt_x_in;
   logic [YW-1:0]     pt_y_ff, pt_y_in;
   logic              pt_vld_ff, pt_vld_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;
   logic              rsp_user_ff, rsp_user_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [CW-1:0]     cx_ff, cx_in;
   logic [CW-1:0]     cy_ff, cy_in;
   logic [RW-1:0]     rx_ff, rx_in;
   logic [RW-1:0]     ry_ff, ry_in;

   logic [MUL_OP_W-1:0] mul_op;
   logic [PW-1:0]       prod;

   logic [CW+1:0]     ym1;
   logic [CW+1:0]     ym1_neg;
   logic [CW:0]       y_mag;
   logic              dec_neg;
   logic              dec_zero;
   logic              r1_exit;
   logic [DW-1:0]     sx_ext;
   logic [DW-1:0]     sy_ext;
   logic              req_fire;
   logic              rsp_free;
   logic [OW-1:0]     px_p, px_m, py_p, py_m, pt_y_ext;

   mpe_mul #(
      .COORD_WIDTH(CW)
   ) u_mul (
      .clock   (clock),
      .op      (mul_op),
      .radius_x(rx_ff),
      .radius_y(ry_ff),
      .rx2     (rx2_ff),
      .ry2     (ry2_ff),
      .off_x   (x_ff),
      .y_mag   (y_mag),
      .prod_ff (prod)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;
   assign rsp_tlast    = rsp_last_ff;

   assign ym1      = {y_ff[YW-1], y_ff} - (CW+2)'(1);
   assign ym1_neg  = -ym1;
   assign y_mag    = ym1[CW+1] ? ym1_neg[CW:0] : ym1[CW:0];
   assign dec_neg  = dec_ff[DW-1];
   assign dec_zero = (dec_ff == '0);
   assign r1_exit  = !($signed(sx_ff) < $signed(sy_ff));
   assign sx_ext   = {{EXT{sx_ff[SW-1]}}, sx_ff};
   assign sy_ext   = {{EXT{sy_ff[SW-1]}}, sy_ff};

   assign pt_y_ext = {pt_y_ff[YW-1], pt_y_ff};
   assign px_p     = OW'(cx_ff) + OW'(pt_x_ff);
   assign px_m     = OW'(cx_ff) - OW'(pt_x_ff);
   assign py_p     = OW'(cy_ff) + pt_y_ext;
   assign py_m     = OW'(cy_ff) - pt_y_ext;

   always_comb begin
      cx_in = cx_ff;
      cy_in = cy_ff;
      rx_in = rx_ff;
      ry_in = ry_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CENTER_X: cx_in = csr_data;
            CSR_CENTER_Y: cy_in = csr_data;
            CSR_RADIUS_X: rx_in = csr_data[RW-1:0];
            CSR_RADIUS_Y: ry_in = csr_data[RW-1:0];
            default:      cx_in = cx_ff;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      restart_in   = restart_ff;
      post_in      = post_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      dec_in       = dec_ff;
      acc_in       = acc_ff;
      rx2_in       = rx2_ff;
      ry2_in       = ry2_ff;
      pt_x_in      = pt_x_ff;
      pt_y_in      = pt_y_ff;
      pt_vld_in    = pt_vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      mul_op       = MUL_NONE;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               restart_in = req_tdata[0];
               post_in    = 1'b0;
               mul_op     = MUL_RX_RX;
               state_in   = S_SQ_RY;
            end
         end
         S_SQ_RY: begin
            rx2_in   = prod[R2W-1:0];
            mul_op   = MUL_RY_RY;
            state_in = S_SQ_DONE;
         end
         S_SQ_DONE: begin
            ry2_in = prod[R2W-1:0];
            if (restart_ff) begin
               mul_op   = MUL_RX2_RY;
               state_in = S_INIT;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_INIT: begin
            x_in     = '0;
            y_in     = YW'(ry_ff);
            sx_in    = '0;
            sy_in    = {prod[SW-2:0], 1'b0};
            dec_in   = DW'(ry2_ff) - DW'(prod) + DW'(rx2_ff >> 2);
            phase_in = PH_R1;
            state_in = S_SETTLE;
         end
         S_SETTLE: begin
            if (phase_ff == PH_R1 && r1_exit) begin
               mul_op   = MUL_X_X1;
               state_in = S_T1;
            end else begin
               if (phase_ff == PH_R2 && y_ff[YW-1]) begin
                  phase_in = PH_DONE;
               end
               state_in = post_ff ? S_PUSH : S_EMIT;
            end
         end
         S_T1: begin
            acc_in   = DW'(ry2_ff >> 2);
            mul_op   = MUL_RY2_P;
            state_in = S_T2;
         end
         S_T2: begin
            acc_in   = acc_ff + DW'(prod);
            mul_op   = MUL_YM1_SQ;
            state_in = S_T3;
         end
         S_T3: begin
            mul_op   = MUL_RX2_P;
            state_in = S_T4;
         end
         S_T4: begin
            acc_in   = acc_ff + DW'(prod);
            mul_op   = MUL_RX2_RY2;
            state_in = S_T5;
         end
         S_T5: begin
            dec_in   = acc_ff - DW'(prod);
            phase_in = PH_R2;
            state_in = S_SETTLE;
         end
         S_EMIT: begin
            if (phase_ff == PH_DONE) begin
               pt_vld_in = 1'b0;
               state_in  = S_PUSH;
            end else begin
               pt_x_in   = x_ff;
               pt_y_in   = y_ff;
               pt_vld_in = 1'b1;
               state_in  = S_STEP1;
            end
         end
         S_STEP1: begin
            tx_in = (phase_ff == PH_R1) || dec_neg || dec_zero;
            ty_in = (phase_ff == PH_R2) || !dec_neg;
            if ((phase_ff == PH_R1) || dec_neg || dec_zero) begin
               x_in  = x_ff + CW'(1);
               sx_in = sx_ff + SW'({ry2_ff, 1'b0});
            end
            if ((phase_ff == PH_R2) || !dec_neg) begin
               y_in  = y_ff - YW'(1);
               sy_in = sy_ff - SW'({rx2_ff, 1'b0});
            end
            acc_in   = dec_ff + ((phase_ff == PH_R1) ? DW'(ry2_ff) : DW'(rx2_ff));
            state_in = S_STEP2;
         end
         S_STEP2: begin
            dec_in   = acc_ff + (tx_ff ? sx_ext : '0) - (ty_ff ? sy_ext : '0);
            post_in  = 1'b1;
            state_in = S_SETTLE;
         end
         S_PUSH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (pt_vld_ff) begin
                  rsp_data_in = RSP_W'({py_m, px_m, py_m, px_p, py_p, px_m, py_p, px_p});
                  rsp_user_in = 1'b1;
                  rsp_last_in = (phase_ff == PH_DONE);
               end else begin
                  rsp_data_in = '0;
                  rsp_user_in = 1'b0;
                  rsp_last_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_DONE;
         x_ff         <= '0;
         y_ff         <= '1;
         sx_ff        <= '0;
         sy_ff        <= '0;
         dec_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cx_ff        <= '0;
         cy_ff        <= '0;
         rx_ff        <= '0;
         ry_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         dec_ff       <= dec_in;
         rsp_valid_ff <= rsp_valid_in;
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         rx_ff        <= rx_in;
         ry_ff        <= ry_in;
      end
   end

   always_ff @(posedge clock) begin
      restart_ff  <= restart_in;
      post_ff     <= post_in;
      tx_ff       <= tx_in;
      ty_ff       <= ty_in;
      acc_ff      <= acc_in;
      rx2_ff      <= rx2_in;
      ry2_ff      <= ry2_in;
      pt_x_ff     <= pt_x_in;
      pt_y_ff     <= pt_y_in;
      pt_vld_ff   <= pt_vld_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

`ifndef SYNTH
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("req accepted while an item is at work");

   a_last_is_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_user_ff)
      else $error("last point set flagged without valid_res");

   a_step_has_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_STEP2 |-> phase_ff != PH_DONE)
      else $error("step taken after the walk ended");

   a_init_region1: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INIT |=> phase_ff == PH_R1 && x_ff == '0)
      else $error("restart did not enter region 1 at x offset zero");
`endif

endmodule
